@@ rtl/core/modular_inverse_euclid_core_defines.svh @@
// assertion macros for the modular inverse core
// no dependencies; included by the top level only
`ifndef MODULAR_INVERSE_EUCLID_CORE_DEFINES_SVH
`define MODULAR_INVERSE_EUCLID_CORE_DEFINES_SVH

// same-cycle implication under reset
`define MIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mie_pkg.sv @@
// shared field widths and types for the modular inverse core
// no dependencies
package mie_pkg;

	localparam int FIELD_W = 31;

	typedef struct packed {
		logic busy;
		logic done;
	} mie_div_stat_t;

endpackage

@@ rtl/core/mie_if.sv @@
// valid/ready channels for request and response items
// depends on mie_pkg
interface mie_req_if;
	import mie_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] value;
	logic [FIELD_W-1:0] modulus;
	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

interface mie_rsp_if;
	import mie_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] inverse;
	logic               no_inverse;
	modport source (output valid, output inverse, output no_inverse, input ready);
	modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

@@ rtl/core/mie_divmul.sv @@
// radix-2 serial divider, one quotient bit per cycle, that also forms
// quotient times coefficient by shift-and-add; depends on mie_pkg
module mie_divmul #(
	parameter int OPW = 31,
	parameter int CW  = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [OPW-1:0]        dividend,
	input  logic [OPW-1:0]        divisor,
	input  logic signed [CW-1:0]  coef,
	output mie_pkg::mie_div_stat_t stat,
	output logic [OPW-1:0]        rem,
	output logic signed [CW-1:0]  prod
);
	import mie_pkg::*;

	localparam int CNTW = $clog2(OPW + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNTW-1:0]      cnt_q;
	logic [OPW-1:0]       dvd_q;
	logic [OPW-1:0]       dvs_q;
	logic [OPW-1:0]       rem_q;
	logic signed [CW-1:0] coef_q;
	logic signed [CW-1:0] prod_q;

	logic [OPW:0]         trial;
	logic [OPW:0]         diff;
	logic                 qbit;
	logic [OPW-1:0]       rem_next;
	logic signed [CW-1:0] prod_next;

	always_comb begin
		trial     = {rem_q, dvd_q[OPW-1]};
		diff      = trial - {1'b0, dvs_q};
		qbit      = (trial >= {1'b0, dvs_q});
		rem_next  = qbit ? diff[OPW-1:0] : trial[OPW-1:0];
		prod_next = (prod_q <<< 1) + (qbit ? coef_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(OPW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			coef_q <= coef;
			rem_q  <= '0;
			prod_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= dvd_q << 1;
			rem_q  <= rem_next;
			prod_q <= prod_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;
	assign prod      = prod_q;

endmodule

@@ rtl/core/modular_inverse_euclid_core.sv @@
// Modular inverse by the extended Euclidean algorithm. One item is worked at a
// time: each Euclid step runs a serial divider that retires one quotient bit per
// cycle; OPW = min(WIDTH-1, 31) operand bits. The result waits in an output
// register, so a new item is taken as soon as the previous one has been handed
// over to it.
// depends on mie_pkg, mie_if, mie_divmul and the defines header
module modular_inverse_euclid_core #(
	parameter int WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	mie_req_if.sink   req,
	mie_rsp_if.source rsp
);
	import mie_pkg::*;

`include "modular_inverse_euclid_core_defines.svh"

	localparam int OPW = (WIDTH - 1 >= FIELD_W) ? FIELD_W : WIDTH - 1;
	localparam int CW  = OPW + 2;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_LIFT  = 3'd3;
	localparam logic [2:0] S_PUSH  = 3'd4;

	logic [2:0]           state_q;
	logic [OPW-1:0]       a_q;
	logic [OPW-1:0]       b_q;
	logic [OPW-1:0]       m_q;
	logic signed [CW-1:0] x0_q;
	logic signed [CW-1:0] x1_q;
	logic [OPW-1:0]       res_q;
	logic                 flag_q;

	logic                 ovalid_q;
	logic [FIELD_W-1:0]   oinv_q;
	logic                 oflag_q;

	logic                 div_start;
	mie_div_stat_t        div_stat;
	logic [OPW-1:0]       div_rem;
	logic signed [CW-1:0] div_prod;
	logic signed [CW-1:0] m_ext;
	logic signed [CW-1:0] lifted;
	logic                 slot_free;

	assign m_ext     = {2'b00, m_q};
	assign lifted    = x1_q[CW-1] ? (x1_q + m_ext) : x1_q;
	assign slot_free = !ovalid_q || rsp.ready;
	assign div_start = (state_q == S_CHECK) && (m_q > OPW'(1)) && (a_q > OPW'(1)) &&
		(b_q != '0);

	mie_divmul #(
		.OPW(OPW),
		.CW (CW)
	) u_divmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(a_q),
		.divisor (b_q),
		.coef    (x0_q),
		.stat    (div_stat),
		.rem     (div_rem),
		.prod    (div_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else if (m_q > OPW'(1) && a_q == OPW'(1)) begin
						state_q <= S_LIFT;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_CHECK;
					end
				end
				S_LIFT: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q  <= req.value[OPW-1:0];
				b_q  <= req.modulus[OPW-1:0];
				m_q  <= req.modulus[OPW-1:0];
				x0_q <= '0;
				x1_q <= CW'(1);
			end
			S_CHECK: begin
				if (m_q == OPW'(1)) begin
					res_q  <= OPW'(1);
					flag_q <= 1'b0;
				end else begin
					res_q  <= '0;
					flag_q <= 1'b1;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					a_q  <= b_q;
					b_q  <= div_rem;
					x1_q <= x0_q;
					x0_q <= x1_q - div_prod;
				end
			end
			S_LIFT: begin
				res_q  <= lifted[OPW-1:0];
				flag_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_PUSH && slot_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && slot_free) begin
			oinv_q  <= FIELD_W'(res_q);
			oflag_q <= flag_q;
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = ovalid_q;
	assign rsp.inverse    = oinv_q;
	assign rsp.no_inverse = oflag_q;

	// flagged items carry a zero inverse
	`MIE_ASSERT_NOW(a_flag_zero, clk, arst_n, rsp.valid && rsp.no_inverse, rsp.inverse == '0, "flagged item with nonzero inverse")
	// divider finishes only while a step is in flight
	`MIE_ASSERT_NOW(a_div_done_state, clk, arst_n, div_stat.done, state_q == S_DIV, "divider done outside a step")
	// lift is reached only once the remainder has come down to one
	`MIE_ASSERT_NOW(a_lift_unit, clk, arst_n, state_q == S_LIFT, a_q == OPW'(1), "lift with remainder other than one")
	// a pushed result shows up on the response channel
	`MIE_ASSERT_NEXT(a_push_valid, clk, arst_n, state_q == S_PUSH && slot_free, rsp.valid, "pushed item not presented")

endmodule

@@ test/tb_top.sv @@
// testbench for modular_inverse_euclid_core: directed and random value/modulus items,
// checked field by field against an in-bench extended Euclid predictor
// depends on mie_pkg, mie_if and the core rtl

typedef struct packed {
	logic [mie_pkg::FIELD_W-1:0] inverse;
	logic                        no_inverse;
} inv_result_t;

// extended euclid on the masked operands
function automatic inv_result_t predict_inverse(input logic [mie_pkg::FIELD_W-1:0] value,
		input logic [mie_pkg::FIELD_W-1:0] modulus);
	longint unsigned a, b, q, r, mval;
	longint          x0, x1, nx;
	bit              fail;
	inv_result_t     res;
	a    = 64'(value);
	mval = 64'(modulus);
	b    = mval;
	x0   = 0;
	x1   = 1;
	fail = 1'b0;
	res  = '0;
	if (mval == 1) begin
		res.inverse = {{(mie_pkg::FIELD_W-1){1'b0}}, 1'b1};
		return res;
	end
	if (mval == 0) begin
		res.no_inverse = 1'b1;
		return res;
	end
	while (a > 1) begin
		if (b == 0) begin
			fail = 1'b1;
			break;
		end
		q  = a / b;
		r  = a % b;
		a  = b;
		b  = r;
		nx = x1 - longint'(q) * x0;
		x1 = x0;
		x0 = nx;
	end
	if (a == 0)
		fail = 1'b1;
	if (fail) begin
		res.no_inverse = 1'b1;
		return res;
	end
	x1 = x1 % longint'(mval);
	if (x1 < 0)
		x1 = x1 + longint'(mval);
	res.inverse = x1[mie_pkg::FIELD_W-1:0];
	return res;
endfunction

class inverse_scoreboard;
	inv_result_t expected_q[$];
	int          mismatches;

	function new();
		mismatches = 0;
	endfunction

	function void note_request(logic [mie_pkg::FIELD_W-1:0] value,
			logic [mie_pkg::FIELD_W-1:0] modulus);
		expected_q.push_back(predict_inverse(value, modulus));
	endfunction

	function void check_response(logic [mie_pkg::FIELD_W-1:0] inverse, logic no_inverse);
		inv_result_t exp_res;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: inverse=%0d no_inverse=%0b", inverse, no_inverse);
			return;
		end
		exp_res = expected_q.pop_front();
		if (inverse !== exp_res.inverse || no_inverse !== exp_res.no_inverse) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected inverse=%0d no_inverse=%0b, got inverse=%0d no_inverse=%0b",
					exp_res.inverse, exp_res.no_inverse, inverse, no_inverse);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_top;
	import mie_pkg::*;

	localparam int          RAND_PER_PHASE = 126;
	localparam int          STALL_LIMIT    = 20000;
	localparam int          HOLD_CYCLES    = 5000;
	localparam logic [30:0] FMAX           = 31'h7fffffff;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   rsp_idle_pct;
	int   phase_id;
	logic hold_rsp;

	inverse_scoreboard sb;

	mie_req_if req_ch();
	mie_rsp_if rsp_ch();

	modular_inverse_euclid_core #(.WIDTH(32)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [FIELD_W-1:0] fib_num(input int k);
		longint unsigned f0, f1, t;
		f0 = 0;
		f1 = 1;
		for (int i = 0; i < k; i++) begin
			t  = f0 + f1;
			f0 = f1;
			f1 = t;
		end
		return f0[FIELD_W-1:0];
	endfunction

	task automatic send_item(input logic [FIELD_W-1:0] value, input logic [FIELD_W-1:0] modulus);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.value   <= value;
		req_ch.modulus <= modulus;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(value, modulus);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		logic [FIELD_W-1:0] v, m;
		int                 g, k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = FIELD_W'($urandom());
				m = FIELD_W'($urandom());
				if (m == '0)
					m = FIELD_W'(1);
			end
			4: begin
				v = FIELD_W'($urandom());
				m = FIELD_W'($urandom_range(1, 64));
			end
			5: begin
				g = $urandom_range(2, 1000);
				m = FIELD_W'(g * $urandom_range(1, 1 << 20));
				v = FIELD_W'(g * $urandom_range(0, 1 << 20));
			end
			6: begin
				v = FIELD_W'($urandom());
				m = FMAX;
			end
			7: begin
				k = $urandom_range(2, 45);
				if ($urandom_range(0, 1)) begin
					v = fib_num(k);
					m = fib_num(k + 1);
				end else begin
					v = fib_num(k + 1);
					m = fib_num(k);
				end
			end
			8: begin
				m = FIELD_W'($urandom());
				if (m == '0)
					m = FIELD_W'(1);
				case ($urandom_range(0, 2))
					0: v = '0;
					1: v = FIELD_W'(1);
					default: v = m - FIELD_W'(1);
				endcase
			end
			default: begin
				m = 31'(1) << $urandom_range(0, 30);
				v = FIELD_W'($urandom());
			end
		endcase
		send_item(v, m);
	endtask

	task automatic run_random_phase(input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		rsp_idle_pct  = r_pct;
		for (int i = 0; i < RAND_PER_PHASE; i++)
			send_random_item();
		wait_drained();
	endtask

	// response side
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.inverse, rsp_ch.no_inverse);
			if (hold_rsp)
				rsp_ch.ready <= 1'b0;
			else
				rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
		end
	end

	// long receiver hold-off while the sender keeps offering items
	initial begin
		int cnt;
		hold_rsp = 1'b0;
		@(posedge clk);
		while (phase_id != 2)
			@(posedge clk);
		repeat (200) @(posedge clk);
		hold_rsp <= 1'b1;
		cnt = 0;
		while (cnt < HOLD_CYCLES) begin
			@(posedge clk);
			cnt++;
		end
		hold_rsp <= 1'b0;
	end

	// stall watchdog
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		sb             = new();
		phase_id       = 0;
		send_idle_pct  = 32;
		rsp_idle_pct   = 50;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.value   = '0;
		req_ch.modulus = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: modulus one, modulus zero, value zero, shared factors, extremes
		send_item(31'd0, 31'd1);
		send_item(FMAX, 31'd1);
		send_item(31'd0, 31'd0);
		send_item(31'd5, 31'd0);
		send_item(31'd0, 31'd7);
		send_item(31'd0, FMAX);
		send_item(31'd1, FMAX);
		send_item(FMAX - 31'd1, FMAX);
		send_item(FMAX, FMAX);
		send_item(31'd3, 31'd7);
		send_item(31'd10, 31'd7);
		send_item(31'd6, 31'd9);
		send_item(FMAX, 31'd2);
		send_item(31'd2, 31'd4);
		send_item(FMAX, FMAX - 31'd1);
		send_item(31'd12345, 31'h40000000);
		send_item(31'h40000000, FMAX);
		send_item(fib_num(45), fib_num(46));
		send_item(fib_num(46), fib_num(45));
		send_item(31'h55555555, 31'h2aaaaaaa);
		send_item(31'h2aaaaaab, 31'h55555555);
		wait_drained();

		run_random_phase(32, 50);
		phase_id = 1;
		run_random_phase(50, 32);
		phase_id = 2;
		run_random_phase(0, 0);

		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
